[src/wdt_pkg.sv]
// wdt_pkg: shared types and constants for the watchdog timer register block.
// No dependencies; used by wdt_regs and watchdog_timer_registers.
`default_nettype none

package wdt_pkg;

   // request kinds (req_tuser)
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   // register byte offsets
   localparam logic [4:0] OFS_STATUS  = 5'h00;
   localparam logic [4:0] OFS_RELOAD  = 5'h04;
   localparam logic [4:0] OFS_RESTART = 5'h08;
   localparam logic [4:0] OFS_CONTROL = 5'h0C;
   localparam logic [4:0] OFS_WIDTH   = 5'h18;

   localparam logic [31:0] RESTART_KEY = 32'h0000_4755;

   // top-byte keys of the reset width register
   localparam logic [7:0] KEY_POL_SET = 8'hA5;
   localparam logic [7:0] KEY_POL_CLR = 8'h5A;
   localparam logic [7:0] KEY_PP_SET  = 8'hA8;
   localparam logic [7:0] KEY_PP_CLR  = 8'h8A;

   // control bit positions
   localparam int CTL_ENABLE = 0;
   localparam int CTL_RESET  = 1;
   localparam int CTL_IRQ    = 2;
   localparam int CTL_EXT    = 3;
   localparam int CTL_WIDTH  = 7;

   localparam logic [1:0] MODE_CPU      = 2'd2;
   localparam logic [1:0] MODE_RESERVED = 2'd3;

   typedef struct packed {
      logic        ext_push_pull;
      logic        ext_signal;
      logic        interrupt_request;
      logic [1:0]  reset_mode;
      logic        reset_request;
      logic        timeout_event;
      logic [31:0] read_data;
   } result_type;

endpackage

`default_nettype wire

[src/wdt_regs.sv]
// wdt_regs: watchdog state registers and the single-pass step logic.
// Depends on wdt_pkg. Result is combinational from state and the request.
`default_nettype none

module wdt_regs #(
   parameter int COUNT_WIDTH = 32,
   parameter int PULSE_WIDTH = 12
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [1:0]         kind,
   input  wire logic [4:0]         address,
   input  wire logic [31:0]        write_data,
   output wdt_pkg::result_type     result
);

   logic [COUNT_WIDTH-1:0]        counter_ff, counter_in;
   logic [COUNT_WIDTH-1:0]        reload_ff, reload_in;
   logic [wdt_pkg::CTL_WIDTH-1:0] control_ff, control_in;
   logic [PULSE_WIDTH-1:0]        pulse_len_ff, pulse_len_in;
   logic [PULSE_WIDTH-1:0]        pulse_rem_ff, pulse_rem_in;
   logic                          polarity_ff, polarity_in;
   logic                          push_pull_ff, push_pull_in;
   logic                          timeout;
   logic [31:0]                   rdata;
   logic [7:0]                    top_byte;
   logic [1:0]                    mode_raw;

   assign top_byte = write_data[31:24];

   always_comb begin
      counter_in   = counter_ff;
      reload_in    = reload_ff;
      control_in   = control_ff;
      pulse_len_in = pulse_len_ff;
      pulse_rem_in = pulse_rem_ff;
      polarity_in  = polarity_ff;
      push_pull_in = push_pull_ff;
      timeout      = 1'b0;
      rdata        = '0;
      case (kind)
         wdt_pkg::KIND_TICK: begin
            if (pulse_rem_ff != '0) begin
               pulse_rem_in = pulse_rem_ff - PULSE_WIDTH'(1);
            end
            if (control_ff[wdt_pkg::CTL_ENABLE]) begin
               if (counter_ff <= COUNT_WIDTH'(1)) begin
                  timeout    = 1'b1;
                  counter_in = reload_ff;
               end else begin
                  counter_in = counter_ff - COUNT_WIDTH'(1);
               end
            end
            if (timeout && control_ff[wdt_pkg::CTL_EXT]) begin
               pulse_rem_in = pulse_len_ff;
            end
         end
         wdt_pkg::KIND_READ: begin
            case (address)
               wdt_pkg::OFS_STATUS:  rdata = 32'(counter_ff);
               wdt_pkg::OFS_RELOAD:  rdata = 32'(reload_ff);
               wdt_pkg::OFS_CONTROL: rdata = 32'(control_ff);
               wdt_pkg::OFS_WIDTH: begin
                  rdata     = 32'(pulse_len_ff);
                  rdata[31] = polarity_ff;
                  rdata[30] = push_pull_ff;
               end
               default: rdata = '0;
            endcase
         end
         wdt_pkg::KIND_WRITE: begin
            case (address)
               wdt_pkg::OFS_RELOAD: reload_in = write_data[COUNT_WIDTH-1:0];
               wdt_pkg::OFS_RESTART: begin
                  if (write_data == wdt_pkg::RESTART_KEY) begin
                     counter_in = reload_ff;
                  end
               end
               wdt_pkg::OFS_CONTROL: control_in = write_data[wdt_pkg::CTL_WIDTH-1:0];
               wdt_pkg::OFS_WIDTH: begin
                  pulse_len_in = write_data[PULSE_WIDTH-1:0];
                  case (top_byte)
                     wdt_pkg::KEY_POL_SET: polarity_in  = 1'b1;
                     wdt_pkg::KEY_POL_CLR: polarity_in  = 1'b0;
                     wdt_pkg::KEY_PP_SET:  push_pull_in = 1'b1;
                     wdt_pkg::KEY_PP_CLR:  push_pull_in = 1'b0;
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // outputs reflect the state after this step
   assign mode_raw = control_in[6:5];

   always_comb begin
      result.read_data         = rdata;
      result.timeout_event     = timeout;
      result.reset_request     = timeout && control_in[wdt_pkg::CTL_RESET];
      result.interrupt_request = timeout && control_in[wdt_pkg::CTL_IRQ];
      result.reset_mode        = (mode_raw == wdt_pkg::MODE_RESERVED) ?
                                 wdt_pkg::MODE_CPU : mode_raw;
      result.ext_signal        = (pulse_rem_in != '0) ? polarity_in : !polarity_in;
      result.ext_push_pull     = push_pull_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         reload_ff    <= '0;
         control_ff   <= '0;
         pulse_len_ff <= '0;
         pulse_rem_ff <= '0;
         polarity_ff  <= 1'b0;
         push_pull_ff <= 1'b0;
      end else if (step) begin
         counter_ff   <= counter_in;
         reload_ff    <= reload_in;
         control_ff   <= control_in;
         pulse_len_ff <= pulse_len_in;
         pulse_rem_ff <= pulse_rem_in;
         polarity_ff  <= polarity_in;
         push_pull_ff <= push_pull_in;
      end
   end

endmodule

`default_nettype wire

[src/watchdog_timer_registers.sv]
// watchdog_timer_registers: top level of the watchdog timer register block.
// Depends on wdt_pkg and wdt_regs.
// A request's result is registered into the response buffer as the request is accepted.
// Throughput: one request per cycle; a two-entry response buffer lets a
// request be taken while an earlier response waits. req_tready drops only
// when both buffer entries are full.
// Reset: synchronous, active high; watchdog registers and buffer count clear, watchdog disabled.
`default_nettype none

module watchdog_timer_registers #(
   parameter int COUNT_WIDTH = 32,
   parameter int PULSE_WIDTH = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [1:0]  req_tuser,   // kind
   input  wire logic [39:0] req_tdata,   // address[4:0], write_data[36:5], zero pad
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[31:0], timeout_event[32], reset_request[33], reset_mode[35:34],
   // interrupt_request[36], ext_signal[37], ext_push_pull[38], zero pad[39]
   output      logic [39:0] rsp_tdata
);

   logic                req_accept;
   logic                rsp_accept;
   wdt_pkg::result_type step_result;
   wdt_pkg::result_type slot0_ff, slot0_in;
   wdt_pkg::result_type slot1_ff, slot1_in;
   logic [1:0]          count_ff, count_in;

   assign req_tready = (count_ff != 2'd2);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // all watchdog state updates happen as the request is accepted
   wdt_regs #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .PULSE_WIDTH (PULSE_WIDTH)
   ) u_regs (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .kind       (req_tuser),
      .address    (req_tdata[4:0]),
      .write_data (req_tdata[36:5]),
      .result     (step_result)
   );

   // two-entry response buffer, slot0 is the head
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      case (count_ff)
         2'd0: begin
            if (req_accept) begin
               slot0_in = step_result;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (req_accept && rsp_accept) begin
               slot0_in = step_result;
            end else if (req_accept) begin
               slot1_in = step_result;
               count_in = 2'd2;
            end else if (rsp_accept) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            if (rsp_accept) begin
               slot0_in = slot1_ff;
               count_in = 2'd1;
            end
         end
         default: count_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_tdata = {1'b0, slot0_ff.ext_push_pull, slot0_ff.ext_signal,
                       slot0_ff.interrupt_request, slot0_ff.reset_mode,
                       slot0_ff.reset_request, slot0_ff.timeout_event,
                       slot0_ff.read_data};

   // reset and interrupt requests only ever ride on a timeout
   a_req_needs_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[33] || rsp_tdata[36]) |-> rsp_tdata[32])
      else $error("reset/interrupt request without timeout");

   // reserved reset mode code is never reported
   a_mode_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[35:34] != wdt_pkg::MODE_RESERVED)
      else $error("reset mode 3 reported");

   // buffer never overflows: a full buffer takes no request
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 && !rsp_tready |=> count_ff == 2'd2)
      else $error("response buffer lost an entry");

   // a request other than a tick never reports a timeout
   a_read_no_timeout: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser != wdt_pkg::KIND_TICK |-> !step_result.timeout_event)
      else $error("timeout on a non-tick request");

endmodule

`default_nettype wire

[bench/tb_top.sv]
// tb_top: self-checking bench for the watchdog timer register block.
// Needs wdt_pkg and watchdog_timer_registers; a predictor checks every response.
`timescale 1ns / 1ps

module tb_top;

   // request kind the block must ignore
   localparam logic [1:0] KIND_NONE = 2'd3;
   // offsets that decode to no register
   localparam logic [4:0] OFS_UNUSED = 5'h1F;
   localparam logic [4:0] OFS_ODD    = 5'h05;
   localparam logic [4:0] OFS_SPARE  = 5'h10;
   // reset mode field sits at control bits 6:5
   localparam int MODE_LSB = 5;
   localparam int USEFUL_TARGET = 950;
   localparam int MAX_IDLE = 6;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;    // kind
   logic [39:0] req_tdata;    // address[4:0], write_data[36:5], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   // read_data[31:0], timeout_event[32], reset_request[33], reset_mode[35:34],
   // interrupt_request[36], ext_signal[37], ext_push_pull[38], zero pad[39]
   logic [39:0] rsp_tdata;

   watchdog_timer_registers uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ---------------------------------------------------------------
   // Predictor state: a private copy of the watchdog registers
   // ---------------------------------------------------------------
   logic [31:0] wd_count;
   logic [31:0] wd_reload;
   logic [6:0]  wd_ctl;
   logic [11:0] wd_pulse_len;
   logic        wd_pol_high;
   logic        wd_push_pull;
   logic [11:0] wd_pulse_left;

   wdt_pkg::result_type pending_responses[$];

   int errors      = 0;
   int n_useful    = 0;
   int n_checked   = 0;
   int n_timeouts  = 0;
   int n_kind[4]   = '{0, 0, 0, 0};
   bit idle_on     = 1'b1;   // both sides draw random gaps when set
   int hold_cycles = 0;      // long receiver hold-off, counted down below

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Expected response for one request; advances the predictor state.
   function automatic wdt_pkg::result_type watchdog_response(input logic [1:0] kind,
                                                             input logic [4:0] addr,
                                                             input logic [31:0] data);
      wdt_pkg::result_type r;
      logic       fired;
      logic [1:0] mode;
      r     = '0;
      fired = 1'b0;
      case (kind)
         wdt_pkg::KIND_TICK: begin
            // a running pulse shortens first, then the counter moves
            if (wd_pulse_left != 0) wd_pulse_left = wd_pulse_left - 1'b1;
            if (wd_ctl[wdt_pkg::CTL_ENABLE]) begin
               if (wd_count <= 32'd1) begin
                  fired    = 1'b1;
                  wd_count = wd_reload;
               end else begin
                  wd_count = wd_count - 1'b1;
               end
            end
            if (fired && wd_ctl[wdt_pkg::CTL_EXT]) wd_pulse_left = wd_pulse_len;
         end
         wdt_pkg::KIND_READ: begin
            case (addr)
               wdt_pkg::OFS_STATUS:  r.read_data = wd_count;
               wdt_pkg::OFS_RELOAD:  r.read_data = wd_reload;
               wdt_pkg::OFS_CONTROL: r.read_data = {25'd0, wd_ctl};
               wdt_pkg::OFS_WIDTH:
                  r.read_data = {wd_pol_high, wd_push_pull, 18'd0, wd_pulse_len};
               default:     r.read_data = '0;
            endcase
         end
         wdt_pkg::KIND_WRITE: begin
            case (addr)
               wdt_pkg::OFS_RELOAD:  wd_reload = data;
               wdt_pkg::OFS_RESTART: if (data == wdt_pkg::RESTART_KEY) wd_count = wd_reload;
               wdt_pkg::OFS_CONTROL: wd_ctl = data[wdt_pkg::CTL_WIDTH-1:0];
               wdt_pkg::OFS_WIDTH: begin
                  wd_pulse_len = data[11:0];
                  case (data[31:24])
                     wdt_pkg::KEY_POL_SET: wd_pol_high  = 1'b1;
                     wdt_pkg::KEY_POL_CLR: wd_pol_high  = 1'b0;
                     wdt_pkg::KEY_PP_SET:  wd_push_pull = 1'b1;
                     wdt_pkg::KEY_PP_CLR:  wd_push_pull = 1'b0;
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      // mode 3 reads back as written but is reported as cpu reset
      mode = wd_ctl[MODE_LSB +: 2];
      if (mode > wdt_pkg::MODE_CPU) mode = wdt_pkg::MODE_CPU;
      r.timeout_event     = fired;
      r.reset_request     = fired & wd_ctl[wdt_pkg::CTL_RESET];
      r.reset_mode        = mode;
      r.interrupt_request = fired & wd_ctl[wdt_pkg::CTL_IRQ];
      r.ext_signal        = (wd_pulse_left != 0) ? wd_pol_high : ~wd_pol_high;
      r.ext_push_pull     = wd_push_pull;
      return r;
   endfunction

   function automatic bit is_register(input logic [4:0] addr);
      return addr inside {wdt_pkg::OFS_STATUS, wdt_pkg::OFS_RELOAD, wdt_pkg::OFS_RESTART,
                          wdt_pkg::OFS_CONTROL, wdt_pkg::OFS_WIDTH};
   endfunction

   function automatic logic [4:0] pick_addr();
      logic [4:0] regs[5];
      regs = '{wdt_pkg::OFS_STATUS, wdt_pkg::OFS_RELOAD, wdt_pkg::OFS_RESTART,
               wdt_pkg::OFS_CONTROL, wdt_pkg::OFS_WIDTH};
      if ($urandom_range(0, 4) == 0) return 5'($urandom_range(0, 31));
      return regs[$urandom_range(0, 4)];
   endfunction

   // Drive one request from a falling edge, hold it until accepted,
   // then log its expected response. Returns at the next falling edge.
   task automatic issue_request(input logic [1:0] kind, input logic [4:0] addr,
                                input logic [31:0] data);
      int                  gap;
      wdt_pkg::result_type want;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, data, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = watchdog_response(kind, addr, data);
      pending_responses.push_back(want);
      n_kind[kind]++;
      if (want.timeout_event) n_timeouts++;
      if (kind == wdt_pkg::KIND_TICK || (kind != KIND_NONE && is_register(addr))) n_useful++;
      @(negedge clock);
   endtask

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
   endtask

   // ---------------------------------------------------------------
   // Response side: random stalls, long hold-off, field-by-field check
   // ---------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) hold_cycles--;
      end
   end

   initial begin
      wdt_pkg::result_type got;
      wdt_pkg::result_type want;
      int                  stall;
      stall      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = wdt_pkg::result_type'(rsp_tdata[38:0]);
            if (pending_responses.size() == 0) begin
               errors++;
               $display("%0t: response with no request outstanding, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = pending_responses.pop_front();
               n_checked++;
               report_field("read_data", want.read_data, got.read_data);
               report_field("timeout_event", want.timeout_event, got.timeout_event);
               report_field("reset_request", want.reset_request, got.reset_request);
               report_field("reset_mode", want.reset_mode, got.reset_mode);
               report_field("interrupt_request", want.interrupt_request,
                            got.interrupt_request);
               report_field("ext_signal", want.ext_signal, got.ext_signal);
               report_field("ext_push_pull", want.ext_push_pull, got.ext_push_pull);
            end
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (hold_cycles == 0);
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_reset_values();
      issue_request(wdt_pkg::KIND_READ, wdt_pkg::OFS_STATUS, '0);
      issue_request(wdt_pkg::KIND_READ, wdt_pkg::OFS_RELOAD, '0);
      issue_request(wdt_pkg::KIND_READ, wdt_pkg::OFS_RESTART, '0);
      issue_request(wdt_pkg::KIND_READ, wdt_pkg::OFS_CONTROL, '0);
      issue_request(wdt_pkg::KIND_READ, wdt_pkg::OFS_WIDTH, '0);
      issue_request(wdt_pkg::KIND_READ, OFS_UNUSED, 32'hFFFF_FFFF);
      // disabled watchdog must not move on a tick
      issue_request(wdt_pkg::KIND_TICK, wdt_pkg::OFS_STATUS, '0);
   endtask

   task automatic test_register_access();
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_RELOAD, 32'hFFFF_FFFF);
      issue_request(wdt_pkg::KIND_READ, wdt_pkg::OFS_RELOAD, '0);
      // near-miss restart value is ignored
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_RESTART,
                    wdt_pkg::RESTART_KEY ^ 32'h1);
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_RESTART, wdt_pkg::RESTART_KEY);
      issue_request(wdt_pkg::KIND_READ, wdt_pkg::OFS_STATUS, '0);
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_STATUS, '0);   // status is read-only
      issue_request(wdt_pkg::KIND_WRITE, OFS_SPARE, 32'h1234_5678);
      issue_request(wdt_pkg::KIND_READ, OFS_ODD, '0);
      issue_request(KIND_NONE, wdt_pkg::OFS_RELOAD, '0);             // unknown kind
   endtask

   task automatic test_width_keys();
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_WIDTH, {wdt_pkg::KEY_POL_SET, 24'h000FFF});
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_WIDTH, {wdt_pkg::KEY_PP_SET, 24'h000002});
      issue_request(wdt_pkg::KIND_READ, wdt_pkg::OFS_WIDTH, '0);
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_WIDTH, {wdt_pkg::KEY_POL_CLR, 24'h000003});
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_WIDTH, {wdt_pkg::KEY_PP_CLR, 24'h000003});
      // no key in the top byte: only the length changes
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_WIDTH, 32'h12FF_F003);
   endtask

   task automatic test_zero_reload();
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_RELOAD, '0);
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_RESTART, wdt_pkg::RESTART_KEY);
      // all control bits, reset mode three
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_CONTROL, 32'h0000_007F);
      issue_request(wdt_pkg::KIND_TICK, wdt_pkg::OFS_STATUS, '0);
      issue_request(wdt_pkg::KIND_TICK, wdt_pkg::OFS_STATUS, '0);
      issue_request(wdt_pkg::KIND_READ, wdt_pkg::OFS_CONTROL, '0);
   endtask

   // Receiver stops for a long stretch; the sender keeps going so the
   // response buffer fills and req_tready has to drop.
   task automatic test_backpressure();
      idle_on     = 1'b0;
      hold_cycles = 120;
      repeat (20) begin
         if ($urandom_range(0, 2) == 0) begin
            issue_request(wdt_pkg::KIND_READ, pick_addr(), $urandom);
         end else begin
            issue_request(wdt_pkg::KIND_TICK, wdt_pkg::OFS_STATUS, $urandom);
         end
      end
      idle_on = 1'b1;
   endtask

   // One watchdog session: program it, arm it, then run ticks with
   // reads, kicks and some noise mixed in.
   task automatic run_session();
      logic [31:0] data;
      logic [7:0]  top;
      int          steps;
      int          pick;
      case ($urandom_range(0, 9))
         0:       data = '0;
         1:       data = $urandom;
         default: data = $urandom_range(1, 12);
      endcase
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_RELOAD, data);
      case ($urandom_range(0, 4))
         0:       top = wdt_pkg::KEY_POL_SET;
         1:       top = wdt_pkg::KEY_POL_CLR;
         2:       top = wdt_pkg::KEY_PP_SET;
         3:       top = wdt_pkg::KEY_PP_CLR;
         default: top = 8'($urandom);
      endcase
      data = $urandom;
      data[31:24] = top;
      // mostly short pulses, now and then the longest
      data[11:0] = ($urandom_range(0, 19) == 0) ? 12'hFFF : 12'($urandom_range(0, 8));
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_WIDTH, data);
      data = $urandom;
      data[wdt_pkg::CTL_ENABLE] = ($urandom_range(0, 9) != 0);
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_CONTROL, data);
      issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_RESTART, wdt_pkg::RESTART_KEY);
      steps = $urandom_range(10, 40);
      repeat (steps) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            issue_request(wdt_pkg::KIND_TICK, 5'($urandom), $urandom);
         end else if (pick < 87) begin
            issue_request(wdt_pkg::KIND_READ, pick_addr(), $urandom);
         end else if (pick < 92) begin
            data = ($urandom_range(0, 3) != 0) ? wdt_pkg::RESTART_KEY : $urandom;
            issue_request(wdt_pkg::KIND_WRITE, wdt_pkg::OFS_RESTART, data);
         end else begin
            issue_request(2'($urandom_range(0, 3)), pick_addr(), $urandom);
         end
      end
   endtask

   task automatic test_random_sessions();
      while (n_useful < USEFUL_TARGET) begin
         // one session in four runs with no idling on either side
         idle_on = ($urandom_range(0, 3) != 0);
         run_session();
      end
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int waited;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = wdt_pkg::KIND_TICK;
      req_tdata  = '0;
      wd_count      = '0;
      wd_reload     = '0;
      wd_ctl        = '0;
      wd_pulse_len  = '0;
      wd_pol_high   = 1'b0;
      wd_push_pull  = 1'b0;
      wd_pulse_left = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_values();
      test_register_access();
      test_width_keys();
      test_zero_reload();
      test_backpressure();
      test_random_sessions();
      req_tvalid <= 1'b0;

      // drain: wait for responses still buffered or held back by receiver stalls
      waited = 0;
      while (pending_responses.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_responses.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_responses.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         repeat (8) @(posedge clock);
         $display("Ran %0d requests: %0d ticks, %0d reads, %0d writes, %0d unknown kind.",
                  n_kind[0] + n_kind[1] + n_kind[2] + n_kind[3],
                  n_kind[0], n_kind[1], n_kind[2], n_kind[3]);
         $display("Checked %0d responses, %0d of them timeouts, with one long stall.",
                  n_checked, n_timeouts);
         if (errors == 0) begin
            $display("Simulation PASSED");
         end else begin
            $display("Simulation FAILED");
         end
         $finish;
      end
   end

   // hard stop well past the slowest legal run
   initial begin
      #2_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
